// File: hw/rtl/keyed_word_hash_2_4_defines.svh
// Assertion macros used by the top-level RTL file of the keyed word hash.
`ifndef KEYED_WORD_HASH_2_4_DEFINES_SVH
`define KEYED_WORD_HASH_2_4_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define KH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("keyed word hash assertion failed");
// Checked at every edge, reset included.
`define KH_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("keyed word hash assertion failed");
`else
`define KH_ASSERT(lbl, prop)
`define KH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/khash_pkg.sv
`timescale 1ns / 1ps
package khash_pkg;

	localparam logic [31:0] LANE_C0     = 32'h7073_6575;
	localparam logic [31:0] LANE_C1     = 32'h6e64_6f6d;
	localparam logic [31:0] LANE_C2     = 32'h6e65_7261;
	localparam logic [31:0] LANE_C3     = 32'h7974_6573;
	localparam logic [31:0] FINAL_MARK  = 32'h0000_00FF;
	localparam logic [31:0] KEY_A_RESET = 32'h3332_3130;
	localparam logic [31:0] KEY_B_RESET = 32'h4241_3938;

	// Register index taken from paddr[2].
	localparam logic REG_KEY_A = 1'b0;
	localparam logic REG_KEY_B = 1'b1;

	localparam int NUM_STAGES  = 6;
	localparam int COMP_ROUNDS = 2;

	typedef logic [3:0][31:0] lanes_t;

	typedef struct packed {
		lanes_t      lanes;
		logic [31:0] msg;
	} stage_t;

	function automatic lanes_t sip_round(input lanes_t l_in);
		lanes_t l;
		l = l_in;
		l[0] = l[0] + l[1];
		l[1] = {l[1][26:0], l[1][31:27]};
		l[1] = l[1] ^ l[0];
		l[0] = {l[0][15:0], l[0][31:16]};
		l[2] = l[2] + l[3];
		l[3] = {l[3][23:0], l[3][31:24]};
		l[3] = l[3] ^ l[2];
		l[0] = l[0] + l[3];
		l[3] = {l[3][24:0], l[3][31:25]};
		l[3] = l[3] ^ l[0];
		l[2] = l[2] + l[1];
		l[1] = {l[1][18:0], l[1][31:19]};
		l[1] = l[1] ^ l[2];
		l[2] = {l[2][15:0], l[2][31:16]};
		return l;
	endfunction

endpackage

// File: hw/rtl/keyed_word_hash_2_4.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// config   | psel penable pwrite  | paddr[2:0] pwdata prdata (pready tied high)
// in       | in_valid in_ready    | message_word[31:0]
// out      | out_valid out_ready  | hash_value[31:0] bucket_index[15:0]
//
// One beat is accepted per cycle while in_ready is high; six pipeline stages,
// one hash round each, lie between acceptance and out_valid.
// Each stage holds its beat while the next one is full, so a stall at the
// output fills the pipeline and in_ready drops only once all stages are full.
// Reset empties all stages and loads the key registers with their defaults.
`include "keyed_word_hash_2_4_defines.svh"
module keyed_word_hash_2_4 import khash_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] message_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value,
	output logic [15:0] bucket_index
);

	logic [31:0] key_a;
	logic [31:0] key_b;

	logic   stg_vld [NUM_STAGES];
	logic   stg_rdy [NUM_STAGES+1];
	stage_t stg_in  [NUM_STAGES];
	stage_t stg_out [NUM_STAGES];

	khash_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key_a   (key_a),
		.key_b   (key_b)
	);

	// Lane setup: start constants mixed with the keys, message into lane three.
	always_comb begin
		stg_in[0].lanes[0] = LANE_C0 ^ key_a;
		stg_in[0].lanes[1] = LANE_C1 ^ key_b;
		stg_in[0].lanes[2] = LANE_C2 ^ key_a;
		stg_in[0].lanes[3] = LANE_C3 ^ key_b ^ message_word;
		stg_in[0].msg      = message_word;
	end

	genvar k;
	generate
		for (k = 1; k < NUM_STAGES; k++) begin : g_link
			if (k == COMP_ROUNDS) begin : g_fin
				// End of compression: message into lane zero, final mark into lane two.
				always_comb begin
					stg_in[k]          = stg_out[k-1];
					stg_in[k].lanes[0] = stg_out[k-1].lanes[0] ^ stg_out[k-1].msg;
					stg_in[k].lanes[2] = stg_out[k-1].lanes[2] ^ FINAL_MARK;
				end
			end else begin : g_pass
				assign stg_in[k] = stg_out[k-1];
			end
		end

		for (k = 0; k < NUM_STAGES; k++) begin : g_stage
			khash_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  ((k == 0) ? in_valid : stg_vld[(k == 0) ? 0 : k-1]),
				.in_ready  (stg_rdy[k]),
				.in_data   (stg_in[k]),
				.out_valid (stg_vld[k]),
				.out_ready (stg_rdy[k+1]),
				.out_data  (stg_out[k])
			);
		end
	endgenerate

	assign stg_rdy[NUM_STAGES] = out_ready;
	assign in_ready            = stg_rdy[0];
	assign out_valid           = stg_vld[NUM_STAGES-1];

	always_comb begin
		hash_value   = stg_out[NUM_STAGES-1].lanes[0] ^ stg_out[NUM_STAGES-1].lanes[1]
			^ stg_out[NUM_STAGES-1].lanes[2] ^ stg_out[NUM_STAGES-1].lanes[3];
		bucket_index = hash_value[31:16] ^ hash_value[15:0];
	end

	`KH_ASSERT(a_accept_fills_first, (in_valid && in_ready) |=> stg_vld[0])
	`KH_ASSERT(a_first_holds, (stg_vld[0] && !stg_rdy[1]) |=> (stg_vld[0] && $stable(stg_out[0])))
	`KH_ASSERT(a_key_a_write, (psel && penable && pwrite && (paddr[2] == REG_KEY_A)) |=> (key_a == $past(pwdata)))
	`KH_ASSERT_ALWAYS(a_ready_when_empty, (!stg_vld[0]) |-> in_ready)

endmodule

// File: hw/rtl/khash_cfg.sv
`timescale 1ns / 1ps
module khash_cfg import khash_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] key_a,
	output logic [31:0] key_b
);

	logic [31:0] key_a_q;
	logic [31:0] key_b_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q <= KEY_A_RESET;
			key_b_q <= KEY_B_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_KEY_A: key_a_q <= pwdata;
				REG_KEY_B: key_b_q <= pwdata;
				default:   key_a_q <= key_a_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_KEY_A: prdata = key_a_q;
			REG_KEY_B: prdata = key_b_q;
			default:   prdata = '0;
		endcase
	end

	assign key_a = key_a_q;
	assign key_b = key_b_q;

endmodule

// File: hw/rtl/khash_stage.sv
`timescale 1ns / 1ps
module khash_stage import khash_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stage_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output stage_t out_data
);

	logic   vld_s;
	stage_t pay_s;

	// The stage takes a new beat whenever it is empty or its beat moves on.
	assign in_ready = !vld_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (in_ready) begin
			vld_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pay_s.lanes <= sip_round(in_data.lanes);
			pay_s.msg   <= in_data.msg;
		end
	end

	assign out_valid = vld_s;
	assign out_data  = pay_s;

endmodule

// File: test/keyed_word_hash_2_4_tb.sv
`timescale 1ns / 1ps
module keyed_word_hash_2_4_tb;
	import khash_pkg::*;

	typedef logic [3:0][31:0] lane_vec_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [15:0] bucket;
	} digest_t;

	localparam logic [2:0] ADDR_KEY_A   = {REG_KEY_A, 2'b00};
	localparam logic [2:0] ADDR_KEY_B   = {REG_KEY_B, 2'b00};
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [31:0] message_word = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [31:0] hash_value;
	logic [15:0] bucket_index;

	logic [31:0] pending_words[$];
	digest_t     expected_digests[$];
	digest_t     oldest_digest;
	logic [31:0] key_a_model = KEY_A_RESET;
	logic [31:0] key_b_model = KEY_B_RESET;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	logic [31:0] directed_words[15] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
		32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_00FF, 32'hFF00_0000,
		32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h3332_3130, 32'h4241_3938
	};

	keyed_word_hash_2_4 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.message_word (message_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value),
		.bucket_index (bucket_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic lane_vec_t mix_round(input lane_vec_t v_in);
		lane_vec_t v;
		v = v_in;
		v[0] = v[0] + v[1];
		v[1] = rol32(v[1], 5) ^ v[0];
		v[0] = rol32(v[0], 16);
		v[2] = v[2] + v[3];
		v[3] = rol32(v[3], 8) ^ v[2];
		v[0] = v[0] + v[3];
		v[3] = rol32(v[3], 7) ^ v[0];
		v[2] = v[2] + v[1];
		v[1] = rol32(v[1], 13) ^ v[2];
		v[2] = rol32(v[2], 16);
		return v;
	endfunction

	function automatic digest_t predict_digest(input logic [31:0] m, input logic [31:0] ka,
			input logic [31:0] kb);
		lane_vec_t   v;
		logic [31:0] h;
		digest_t     d;
		int          r;
		v[0] = LANE_C0 ^ ka;
		v[1] = LANE_C1 ^ kb;
		v[2] = LANE_C2 ^ ka;
		v[3] = LANE_C3 ^ kb ^ m;
		v = mix_round(v);
		v = mix_round(v);
		v[0] = v[0] ^ m;
		v[2] = v[2] ^ FINAL_MARK;
		for (r = 0; r < 4; r++)
			v = mix_round(v);
		h = v[0] ^ v[1] ^ v[2] ^ v[3];
		d.hash = h;
		d.bucket = h[31:16] ^ h[15:0];
		return d;
	endfunction

	// Mostly full-width words, with some short values and single bits mixed in.
	function automatic logic [31:0] random_word();
		case ($urandom_range(5))
			3: return $urandom_range(255);
			4: return ~$urandom_range(255);
			5: return 32'h1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_digests.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_key(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_KEY_A)
			key_a_model = data;
		else if (addr == ADDR_KEY_B)
			key_b_model = data;
	endtask

	// The drain at the end of each batch holds the sender off until all digests are back.
	task automatic run_batch(input int count);
		int i;
		for (i = 0; i < count; i++)
			pending_words.push_back(random_word());
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			message_word <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_digests.push_back(predict_digest(message_word, key_a_model,
					key_b_model));
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid     <= 1'b1;
					message_word <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if (out_valid && out_ready) begin
				if (expected_digests.size() == 0) begin
					report_mismatch("unexpected result beat", hash_value, '0);
				end else begin
					oldest_digest = expected_digests.pop_front();
					if (hash_value !== oldest_digest.hash)
						report_mismatch("hash_value", hash_value, oldest_digest.hash);
					if (bucket_index !== oldest_digest.bucket)
						report_mismatch("bucket_index", {16'h0, bucket_index},
							{16'h0, oldest_digest.bucket});
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 29;
		recv_idle_pct = 77;
		foreach (directed_words[i])
			pending_words.push_back(directed_words[i]);
		wait_idle();
		run_batch(250);
		run_batch(250);
		write_key(ADDR_KEY_A, 32'h0000_0000);
		write_key(ADDR_KEY_B, 32'h0000_0000);
		run_batch(250);

		send_idle_pct = 77;
		recv_idle_pct = 29;
		write_key(ADDR_KEY_A, 32'hFFFF_FFFF);
		write_key(ADDR_KEY_B, 32'hFFFF_FFFF);
		run_batch(300);
		write_key(ADDR_KEY_A, 32'h0000_0000);
		run_batch(200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_key(ADDR_KEY_A, $urandom);
		write_key(ADDR_KEY_B, $urandom);
		run_batch(400);
		write_key(ADDR_KEY_B, $urandom);
		run_batch(350);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_digests.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
